// ===== src/mrbf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mrbf_pkg;

  localparam int unsigned ID_W    = 16;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned STAMP_W = 64;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_DATA = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic        [ID_W-1:0]    sensor_id;
    logic        [VALUE_W-1:0] value_bits;
    logic signed [STAMP_W-1:0] timestamp;
  } rec_t;

  // control held beside the record memory's read register
  typedef struct packed {
    status_t status;
    logic    released;
  } res_ctl_t;

endpackage

`default_nettype wire

// ===== src/mrbf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mrbf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/multi_reader_broadcast_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_action, in_reader, in_sensor_id,
//                                            in_value_bits, in_timestamp
// out      output     out_valid / out_ready  out_status, out_sensor_id,
//                                            out_value_bits, out_timestamp, out_released
// cfg      input      cfg_valid / cfg_ready  cfg_active_readers
//
// One item a cycle while in_ready is high; each result appears in the cycle after its item
// is accepted, as the record memory has a registered read.
// Head, fill count and reader offsets update at acceptance; read marks follow
// from the offsets, so only the records sit in memory.
// Reset (rst_n low, synchronous) empties the buffer and registers all readers.
// in_ready drops only while a result waits and out_ready is low; cfg is always ready.

module multi_reader_broadcast_fifo #(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned NUM_READERS = 2
) (
  input  wire logic                                                    clk,
  input  wire logic                                                    rst_n,
  input  wire logic                                                    in_valid,
  output logic                                                         in_ready,
  input  wire logic                                                    in_action,
  input  wire logic [((NUM_READERS > 1) ? $clog2(NUM_READERS) : 1)-1:0] in_reader,
  input  wire logic        [mrbf_pkg::ID_W-1:0]                        in_sensor_id,
  input  wire logic        [mrbf_pkg::VALUE_W-1:0]                     in_value_bits,
  input  wire logic signed [mrbf_pkg::STAMP_W-1:0]                     in_timestamp,
  output logic                                                         out_valid,
  input  wire logic                                                    out_ready,
  output logic [1:0]                                                   out_status,
  output logic        [mrbf_pkg::ID_W-1:0]                             out_sensor_id,
  output logic        [mrbf_pkg::VALUE_W-1:0]                          out_value_bits,
  output logic signed [mrbf_pkg::STAMP_W-1:0]                          out_timestamp,
  output logic                                                         out_released,
  input  wire logic                                                    cfg_valid,
  output logic                                                         cfg_ready,
  input  wire logic [NUM_READERS-1:0]                                  cfg_active_readers
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned OW = $clog2(DEPTH + 1);
  localparam int unsigned RW = (NUM_READERS > 1) ? $clog2(NUM_READERS) : 1;
  localparam int unsigned RECW = $bits(mrbf_pkg::rec_t);

  logic [NUM_READERS-1:0] active_r;
  logic [AW-1:0]          head_r, head_nxt;
  logic [OW-1:0]          fill_r, fill_nxt;
  logic [OW-1:0]          off_r   [NUM_READERS];
  logic [OW-1:0]          off_nxt [NUM_READERS];
  logic [OW-1:0]          off_upd [NUM_READERS];

  logic                   ov_r, ov_nxt;
  mrbf_pkg::res_ctl_t     octl_r, octl_nxt;
  logic                   rd_flag_r, rd_flag_nxt;

  logic                   in_acc;
  logic [NUM_READERS-1:0] hit;
  logic [NUM_READERS-1:0] can_rd;
  logic                   rd_ok;
  logic                   ins_ok;
  logic                   rel;
  logic [OW-1:0]          sel_off;
  logic [OW-1:0]          slot_off;
  logic [OW:0]            slot_sum;
  logic [AW-1:0]          slot;
  logic [AW-1:0]          head_inc;

  mrbf_pkg::rec_t         wr_rec;
  mrbf_pkg::rec_t         rd_rec;
  logic [RECW-1:0]        rd_raw;

  assign cfg_ready = 1'b1;
  assign in_ready  = !ov_r || out_ready;
  assign in_acc    = in_valid && in_ready;

  // per-reader view of a read: selected, registered and still holding unread records
  always_comb begin
    sel_off = '0;
    for (int r = 0; r < NUM_READERS; r++) begin
      hit[r]    = (in_reader == RW'(r));
      can_rd[r] = hit[r] && (in_action == mrbf_pkg::ACT_READ) && active_r[r] &&
                  (off_r[r] < fill_r);
      sel_off   = sel_off | (hit[r] ? off_r[r] : '0);
    end
  end

  assign rd_ok  = (in_action == mrbf_pkg::ACT_READ) && (|can_rd);
  assign ins_ok = (in_action == mrbf_pkg::ACT_INSERT) && (fill_r != OW'(DEPTH));

  // slot at an offset from the head, wrapped once
  assign slot_off = (in_action == mrbf_pkg::ACT_READ) ? sel_off : fill_r;
  assign slot_sum = {{(OW + 1 - AW){1'b0}}, head_r} + {1'b0, slot_off};
  always_comb begin
    if (slot_sum >= (OW + 1)'(DEPTH)) begin
      slot = AW'(slot_sum - (OW + 1)'(DEPTH));
    end else begin
      slot = AW'(slot_sum);
    end
  end

  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);

  // a reader has marked the head exactly when its offset is non-zero
  always_comb begin
    rel = rd_ok;
    for (int r = 0; r < NUM_READERS; r++) begin
      off_upd[r] = off_r[r] + OW'(can_rd[r]);
      if (active_r[r] && (off_upd[r] == '0)) begin
        rel = 1'b0;
      end
    end
  end

  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    for (int r = 0; r < NUM_READERS; r++) begin
      off_nxt[r] = off_r[r];
    end
    if (in_acc) begin
      if (ins_ok) begin
        fill_nxt = fill_r + OW'(1);
      end
      for (int r = 0; r < NUM_READERS; r++) begin
        off_nxt[r] = off_upd[r];
        if (rel && (off_upd[r] != '0)) begin
          off_nxt[r] = off_upd[r] - OW'(1);
        end
      end
      if (rel) begin
        head_nxt = head_inc;
        fill_nxt = fill_r - OW'(1);
      end
    end
  end

  always_comb begin
    ov_nxt   = ov_r;
    octl_nxt = octl_r;
    if (in_acc) begin
      ov_nxt            = 1'b1;
      octl_nxt.released = rel;
      if (rd_ok || ins_ok) begin
        octl_nxt.status = mrbf_pkg::ST_OK;
      end else if (in_action == mrbf_pkg::ACT_READ) begin
        octl_nxt.status = mrbf_pkg::ST_NO_DATA;
      end else begin
        octl_nxt.status = mrbf_pkg::ST_FULL;
      end
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '1;
      head_r   <= '0;
      fill_r   <= '0;
      ov_r     <= 1'b0;
      octl_r   <= '{status: mrbf_pkg::ST_OK, released: 1'b0};
      for (int r = 0; r < NUM_READERS; r++) begin
        off_r[r] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        active_r <= cfg_active_readers;
      end
      head_r <= head_nxt;
      fill_r <= fill_nxt;
      ov_r   <= ov_nxt;
      octl_r <= octl_nxt;
      for (int r = 0; r < NUM_READERS; r++) begin
        off_r[r] <= off_nxt[r];
      end
    end
  end

  assign wr_rec.sensor_id  = in_sensor_id;
  assign wr_rec.value_bits = in_value_bits;
  assign wr_rec.timestamp  = in_timestamp;

  // a read slot always holds a record, so it never meets the insert slot
  mrbf_ram #(
    .WIDTH (RECW),
    .DEPTH (DEPTH)
  ) u_rec_ram (
    .clk   (clk),
    .we    (in_acc && ins_ok),
    .waddr (slot),
    .wdata (wr_rec),
    .re    (in_acc && rd_ok),
    .raddr (slot),
    .rdata (rd_raw)
  );

  assign rd_rec = rd_raw;

  // data only for a successful read; drop it otherwise
  assign out_valid      = ov_r;
  assign out_status     = octl_r.status;
  assign out_released   = octl_r.released;
  assign out_sensor_id  = (octl_r.status == mrbf_pkg::ST_OK && rd_flag_r) ?
                          rd_rec.sensor_id : '0;
  assign out_value_bits = (octl_r.status == mrbf_pkg::ST_OK && rd_flag_r) ?
                          rd_rec.value_bits : '0;
  assign out_timestamp  = (octl_r.status == mrbf_pkg::ST_OK && rd_flag_r) ?
                          rd_rec.timestamp : '0;

  // mark results that carry a record, as against a successful insert
  always_comb begin
    rd_flag_nxt = rd_flag_r;
    if (in_acc) begin
      rd_flag_nxt = rd_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_flag_r <= 1'b0;
    end else begin
      rd_flag_r <= rd_flag_nxt;
    end
  end

endmodule

`default_nettype wire
